// ===== hw/rtl/sdes_pkg.sv =====
// S-DES package: command codes, permutation and S-box tables, and the
// bit-level round functions used by the cipher pipeline.
// No dependencies.
package sdes_pkg;

   // Number of register stages between the request and response channels
   localparam int unsigned STAGES = 5;

   typedef enum logic [1:0] {
      CMD_ENCRYPT = 2'd0,
      CMD_DECRYPT = 2'd1,
      CMD_DOUBLE  = 2'd2,
      CMD_SPARE   = 2'd3
   } sdes_cmd_type;

   typedef logic [7:0] sdes_block_type;
   typedef logic [9:0] sdes_key_type;
   typedef logic [7:0] sdes_subkey_type;

   typedef struct packed {
      sdes_subkey_type k1;
      sdes_subkey_type k2;
   } sdes_subkeys_type;

   // Per-stage load enables from the pipeline control
   typedef struct packed {
      logic [STAGES-1:0] load;
   } sdes_ctl_type;

   // Table position 1 is the most significant bit
   localparam int unsigned P10_TAB [10] = '{3, 5, 2, 7, 4, 10, 1, 9, 8, 6};
   localparam int unsigned P8_TAB  [8]  = '{6, 3, 7, 4, 8, 5, 10, 9};
   localparam int unsigned IP_TAB  [8]  = '{2, 6, 3, 1, 4, 8, 5, 7};
   localparam int unsigned IPI_TAB [8]  = '{4, 1, 3, 5, 7, 2, 8, 6};
   localparam int unsigned EP_TAB  [8]  = '{4, 1, 2, 3, 2, 3, 4, 1};
   localparam int unsigned P4_TAB  [4]  = '{2, 4, 3, 1};

   localparam logic [1:0] SBOX0 [4][4] = '{
      '{2'd1, 2'd0, 2'd3, 2'd2},
      '{2'd3, 2'd2, 2'd1, 2'd0},
      '{2'd0, 2'd2, 2'd1, 2'd3},
      '{2'd3, 2'd1, 2'd3, 2'd2}
   };
   localparam logic [1:0] SBOX1 [4][4] = '{
      '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd2, 2'd0, 2'd1, 2'd3},
      '{2'd3, 2'd0, 2'd1, 2'd0},
      '{2'd2, 2'd1, 2'd0, 2'd3}
   };

   function automatic logic [9:0] sdes_p10(logic [9:0] v);
      logic [9:0] r;
      for (int i = 0; i < 10; i++) begin
         r[9-i] = v[10-P10_TAB[i]];
      end
      return r;
   endfunction

   function automatic logic [7:0] sdes_p8(logic [9:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[10-P8_TAB[i]];
      end
      return r;
   endfunction

   function automatic logic [7:0] sdes_ip(logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[8-IP_TAB[i]];
      end
      return r;
   endfunction

   function automatic logic [7:0] sdes_ipinv(logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[8-IPI_TAB[i]];
      end
      return r;
   endfunction

   // Key schedule: pure wiring, rotate halves by 1 then by 2 more
   function automatic sdes_subkeys_type sdes_subkeys(logic [9:0] key);
      logic [9:0] p;
      logic [4:0] l1, r1, l3, r3;
      sdes_subkeys_type sk;
      p  = sdes_p10(key);
      l1 = {p[8:5], p[9]};
      r1 = {p[3:0], p[4]};
      l3 = {l1[2:0], l1[4:3]};
      r3 = {r1[2:0], r1[4:3]};
      sk.k1 = sdes_p8({l1, r1});
      sk.k2 = sdes_p8({l3, r3});
      return sk;
   endfunction

   // One fk round: mix the right half into the left half under a subkey
   function automatic logic [7:0] sdes_fk(logic [7:0] x, logic [7:0] sk);
      logic [3:0] right;
      logic [7:0] ep;
      logic [7:0] t;
      logic [3:0] s;
      logic [3:0] p4;
      right = x[3:0];
      for (int i = 0; i < 8; i++) begin
         ep[7-i] = right[4-EP_TAB[i]];
      end
      t = ep ^ sk;
      s = {SBOX0[{t[7], t[4]}][{t[6], t[5]}], SBOX1[{t[3], t[0]}][{t[2], t[1]}]};
      for (int i = 0; i < 4; i++) begin
         p4[3-i] = s[4-P4_TAB[i]];
      end
      return {x[7:4] ^ p4, right};
   endfunction

   // First half of a pass: IP, round, half swap
   function automatic logic [7:0] sdes_half1(logic [7:0] blk, logic [7:0] sk);
      logic [7:0] y;
      y = sdes_fk(sdes_ip(blk), sk);
      return {y[3:0], y[7:4]};
   endfunction

   // Second half of a pass: round, inverse IP
   function automatic logic [7:0] sdes_half2(logic [7:0] x, logic [7:0] sk);
      return sdes_ipinv(sdes_fk(x, sk));
   endfunction

endpackage

// ===== hw/rtl/sdes_pipe_ctl.sv =====
// S-DES pipeline control: valid bits and per-stage load enables with
// backpressure. Depends on sdes_pkg.
module sdes_pipe_ctl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output sdes_pkg::sdes_ctl_type ctl
);
   import sdes_pkg::*;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] prev_valid;
   logic [STAGES:0]   ready;

   // A stage may load when it is empty or its content moves on
   always_comb begin
      ready[STAGES] = out_ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      prev_valid = {valid_ff[STAGES-2:0], in_valid};
      for (int i = 0; i < STAGES; i++) begin
         valid_in[i]    = ready[i] ? prev_valid[i] : valid_ff[i];
         ctl.load[i]    = ready[i] && prev_valid[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[STAGES-1];

endmodule

// ===== hw/rtl/sdes_block_cipher_top.sv =====
// S-DES block cipher, top level: five-stage pipeline for encrypt, decrypt
// and double encrypt. Depends on sdes_pkg and sdes_pipe_ctl.
//
//   channel  dir  tdata                                    tuser
//   req_     in   data_block, first_key, second_key        command
//   rsp_     out  result_block                             -
//
// One item enters per cycle unless a stall on rsp_ has filled the stages;
// each result passes through the five register stages (key schedule, two
// half passes under the first key, two half passes under the second key).
// Non-double commands ride through the last two stages unchanged.
// Synchronous reset empties all stages. A stall on rsp_ holds each full stage
// with no empty one after it; empty ones fill, bubbles squeeze out, nothing drops.
module sdes_block_cipher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [7:0] data_block, [17:8] first_key,
                                    // [27:18] second_key, [31:28] zero
   input  logic [1:0]  req_tuser,   // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [7:0] result_block
);
   import sdes_pkg::*;

   sdes_ctl_type     ctl;

   sdes_block_type   in_block;
   sdes_cmd_type     in_cmd;
   sdes_subkeys_type in_sk1;
   sdes_subkeys_type in_sk2;

   // Stage 0: block and all four subkeys in use order
   sdes_block_type   blk0_ff;
   sdes_subkey_type  ka0_ff, kb0_ff, kc0_ff, kd0_ff;
   logic             dbl0_ff;
   // Stage 1: after first half pass
   sdes_block_type   x1_ff;
   sdes_subkey_type  kb1_ff, kc1_ff, kd1_ff;
   logic             dbl1_ff;
   // Stage 2: after first full pass
   sdes_block_type   y2_ff;
   sdes_subkey_type  kc2_ff, kd2_ff;
   logic             dbl2_ff;
   // Stage 3: after first half of second pass
   sdes_block_type   x3_ff;
   sdes_subkey_type  kd3_ff;
   logic             dbl3_ff;
   // Stage 4: output register
   sdes_block_type   y4_ff;

   sdes_block_type   x3_in;
   sdes_block_type   y4_in;

   sdes_pipe_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .ctl       (ctl)
   );

   // Unpack the item; key schedule is wiring only
   always_comb begin
      in_block = req_tdata[7:0];
      in_cmd   = sdes_cmd_type'(req_tuser);
      in_sk1   = sdes_subkeys(req_tdata[17:8]);
      in_sk2   = sdes_subkeys(req_tdata[27:18]);
   end

   // Decrypt applies the subkeys in reverse order
   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         blk0_ff <= in_block;
         ka0_ff  <= (in_cmd == CMD_DECRYPT) ? in_sk1.k2 : in_sk1.k1;
         kb0_ff  <= (in_cmd == CMD_DECRYPT) ? in_sk1.k1 : in_sk1.k2;
         kc0_ff  <= in_sk2.k1;
         kd0_ff  <= in_sk2.k2;
         dbl0_ff <= (in_cmd == CMD_DOUBLE);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         x1_ff   <= sdes_half1(blk0_ff, ka0_ff);
         kb1_ff  <= kb0_ff;
         kc1_ff  <= kc0_ff;
         kd1_ff  <= kd0_ff;
         dbl1_ff <= dbl0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         y2_ff   <= sdes_half2(x1_ff, kb1_ff);
         kc2_ff  <= kc1_ff;
         kd2_ff  <= kd1_ff;
         dbl2_ff <= dbl1_ff;
      end
   end

   // Second pass only for double encrypt; otherwise carry the result along
   always_comb begin
      x3_in = dbl2_ff ? sdes_half1(y2_ff, kc2_ff) : y2_ff;
      y4_in = dbl3_ff ? sdes_half2(x3_ff, kd3_ff) : x3_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         x3_ff   <= x3_in;
         kd3_ff  <= kd2_ff;
         dbl3_ff <= dbl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         y4_ff <= y4_in;
      end
   end

   assign rsp_tdata = y4_ff;

endmodule

// ===== hw/rtl/sdes_chk.sv =====
// S-DES port checker: latency, flow and reset properties seen at the top
// level's ports, bound to sdes_block_cipher_top. No package dependency.
module sdes_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   // A stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // Input is never blocked while the output stage can move
   a_no_idle_block: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("request blocked while output free");

   // Without stalls a result appears once its item has passed every stage
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready
         ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("result missing after pipeline latency");

endmodule

bind sdes_block_cipher_top sdes_chk u_sdes_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/sdes_block_cipher_tb.sv =====
// Self-checking bench for the S-DES block cipher top: random handshakes on both
// streams, and a scoreboard class that predicts each result block bit for bit.
// Depends on sdes_pkg (command codes, pipeline depth) and sdes_block_cipher_top.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sdes_pkg::*;

   // Scoreboard: predicts result blocks in acceptance order and checks them
   class sdes_result_scoreboard;
      // S-box contents, entry (row, col) at bits [2*(4*row+col) +: 2]
      localparam logic [31:0] LEFT_BOX = {2'd2, 2'd3, 2'd1, 2'd3, 2'd3, 2'd1, 2'd2, 2'd0,
                                          2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd0, 2'd1};
      localparam logic [31:0] RIGHT_BOX = {2'd3, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd0, 2'd3,
                                           2'd3, 2'd1, 2'd0, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0};

      logic [7:0]  expected_blocks[$];
      int unsigned mismatches;
      int unsigned strays;
      int unsigned checked;
      int unsigned per_command[4];

      function logic [1:0] box_lookup(logic [31:0] box, logic [1:0] row, logic [1:0] col);
         return box[2 * (4 * row + col) +: 2];
      endfunction

      // Round key pair from a 10-bit key: P10, rotate halves by 1 and 3, P8
      function logic [15:0] round_keys(logic [9:0] key);
         logic [9:0] p;
         logic [9:0] once;
         logic [9:0] thrice;
         p = {key[7], key[5], key[8], key[3], key[6], key[0], key[9], key[1], key[2], key[4]};
         once   = {p[8:5], p[9], p[3:0], p[4]};
         thrice = {p[6:5], p[9:7], p[1:0], p[4:2]};
         return {once[4], once[7], once[3], once[6], once[2], once[5], once[0], once[1],
                 thrice[4], thrice[7], thrice[3], thrice[6], thrice[2], thrice[5],
                 thrice[0], thrice[1]};
      endfunction

      // Feistel round: the right nibble passes, the left takes the mixed value
      function logic [7:0] feistel(logic [7:0] x, logic [7:0] rk);
         logic [3:0] r;
         logic [7:0] t;
         logic [3:0] s;
         r = x[3:0];
         t = {r[0], r[3], r[2], r[1], r[2], r[1], r[0], r[3]} ^ rk;
         s = {box_lookup(LEFT_BOX, {t[7], t[4]}, {t[6], t[5]}),
              box_lookup(RIGHT_BOX, {t[3], t[0]}, {t[2], t[1]})};
         return {x[7:4] ^ {s[2], s[0], s[1], s[3]}, r};
      endfunction

      function logic [7:0] cipher_pass(logic [7:0] blk, logic [7:0] ka, logic [7:0] kb);
         logic [7:0] x;
         x = {blk[6], blk[2], blk[5], blk[7], blk[4], blk[0], blk[3], blk[1]};
         x = feistel(x, ka);
         x = feistel({x[3:0], x[7:4]}, kb);
         return {x[4], x[7], x[5], x[3], x[1], x[6], x[0], x[2]};
      endfunction

      function logic [7:0] encrypt_block(logic [7:0] blk, logic [9:0] key);
         logic [15:0] rk;
         rk = round_keys(key);
         return cipher_pass(blk, rk[15:8], rk[7:0]);
      endfunction

      function void note_request(sdes_cmd_type cmd, logic [7:0] blk, logic [9:0] key_a,
                                 logic [9:0] key_b);
         logic [15:0] rk;
         logic [7:0]  res;
         case (cmd)
            CMD_DECRYPT: begin
               rk  = round_keys(key_a);
               res = cipher_pass(blk, rk[7:0], rk[15:8]);
            end
            CMD_DOUBLE: begin
               res = encrypt_block(encrypt_block(blk, key_a), key_b);
            end
            // spare code behaves as plain encrypt
            default: begin
               res = encrypt_block(blk, key_a);
            end
         endcase
         expected_blocks = {expected_blocks, res};
         per_command[cmd]++;
      endfunction

      function void check_response(logic [7:0] got);
         logic [7:0] want;
         if (expected_blocks.size() == 0) begin
            strays++;
            $display("%0t: result_block %02h arrived with nothing outstanding", $time, got);
            return;
         end
         want = expected_blocks.pop_front();
         checked++;
         if (got !== want) begin
            mismatches++;
            $display("%0t: result_block mismatch, expected %02h, actual %02h",
                     $time, want, got);
         end
      endfunction

      function int unsigned pending();
         return expected_blocks.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = CMD_ENCRYPT;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;

   // Idle modes per phase: when off, that side never pauses
   bit gaps_on;
   bit stalls_on;

   sdes_result_scoreboard blocks_sb;

   sdes_block_cipher_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Present one item after an optional gap; hold it until the block takes it
   task automatic send_item(sdes_cmd_type cmd, logic [7:0] blk, logic [9:0] key_a,
                            logic [9:0] key_b);
      int unsigned gap;
      gap = gaps_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, key_b, key_a, blk};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      blocks_sb.note_request(cmd, blk, key_a, key_b);
   endtask

   // Keys mostly uniform, now and then pinned to an extreme
   function automatic logic [9:0] draw_key();
      case ($urandom_range(0, 9))
         0:       return 10'h000;
         1:       return 10'h3FF;
         default: return 10'($urandom_range(0, 1023));
      endcase
   endfunction

   task automatic send_random_item();
      send_item(sdes_cmd_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                draw_key(), draw_key());
   endtask

   // Drop valid and hold off until every outstanding result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (blocks_sb.pending() != 0) @(posedge clock);
   endtask

   // Result side: stall for a drawn number of cycles, then take one item
   initial begin
      int unsigned stall;
      @(negedge reset);
      forever begin
         stall = stalls_on ? $urandom_range(0, 14) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Check every accepted result item
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         blocks_sb.check_response(rsp_tdata);
      end
   end

   initial begin
      int unsigned failures;
      blocks_sb = new();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, every command, ignored second key, spare code
      send_item(CMD_ENCRYPT, 8'h00, 10'h000, 10'h000);
      send_item(CMD_ENCRYPT, 8'hFF, 10'h3FF, 10'h000);
      send_item(CMD_ENCRYPT, 8'hFF, 10'h000, 10'h3FF);
      send_item(CMD_ENCRYPT, 8'h00, 10'h3FF, 10'h3FF);
      send_item(CMD_ENCRYPT, 8'h01, 10'h001, 10'h000);
      send_item(CMD_ENCRYPT, 8'h80, 10'h200, 10'h155);
      send_item(CMD_ENCRYPT, 8'hAA, 10'h282, 10'h2AA);
      send_item(CMD_DECRYPT, 8'h00, 10'h000, 10'h3FF);
      send_item(CMD_DECRYPT, 8'hFF, 10'h3FF, 10'h000);
      send_item(CMD_DECRYPT, 8'hAA, 10'h282, 10'h3FF);
      send_item(CMD_DECRYPT, 8'h55, 10'h155, 10'h2AA);
      send_item(CMD_DOUBLE,  8'h00, 10'h000, 10'h3FF);
      send_item(CMD_DOUBLE,  8'hFF, 10'h3FF, 10'h000);
      send_item(CMD_DOUBLE,  8'h55, 10'h155, 10'h2AA);
      send_item(CMD_DOUBLE,  8'hFF, 10'h3FF, 10'h3FF);
      send_item(CMD_DOUBLE,  8'h00, 10'h000, 10'h000);
      send_item(CMD_SPARE,   8'h00, 10'h000, 10'h000);
      send_item(CMD_SPARE,   8'hFF, 10'h3FF, 10'h2AA);
      send_item(CMD_SPARE,   8'h5A, 10'h1C3, 10'h3FF);
      drain();

      // Random: eleven phases of fifty items; idle modes drawn from phase 2 on
      for (int phase = 0; phase < 11; phase++) begin
         case (phase)
            0: begin
               gaps_on   = 1'b1;
               stalls_on = 1'b1;
            end
            1: begin
               gaps_on   = 1'b0;
               stalls_on = 1'b0;
            end
            default: begin
               gaps_on   = 1'($urandom_range(0, 1));
               stalls_on = 1'($urandom_range(0, 1));
            end
         endcase
         for (int n = 0; n < 50; n++) begin
            send_random_item();
         end
         if (phase == 5) begin
            drain();
         end
      end

      drain();
      repeat (STAGES * 4) @(posedge clock);

      failures = blocks_sb.mismatches + blocks_sb.strays + blocks_sb.pending();
      $display("Covered %0d encrypt, %0d decrypt, %0d double and %0d spare-code items",
               blocks_sb.per_command[CMD_ENCRYPT], blocks_sb.per_command[CMD_DECRYPT],
               blocks_sb.per_command[CMD_DOUBLE], blocks_sb.per_command[CMD_SPARE]);
      $display("%0d result blocks checked under random gaps and back-pressure",
               blocks_sb.checked);
      if (failures == 0) begin
         $display("sdes_block_cipher_top regression: pass");
      end else begin
         $display("sdes_block_cipher_top regression: fail");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #5ms;
      $display("sdes_block_cipher_top regression: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/sdes_pkg.sv
hw/rtl/sdes_pipe_ctl.sv
hw/rtl/sdes_block_cipher_top.sv
hw/rtl/sdes_chk.sv
tb/sdes_block_cipher_tb.sv
